FILE: hw/rtl/contiguous_page_allocator_assert.svh
// Assertion macros for the contiguous page allocator.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CPA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("contiguous_page_allocator: check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("contiguous_page_allocator: check failed");

`endif

FILE: hw/rtl/cpa_pkg.sv
// Types and constants shared by the contiguous page allocator.
package cpa_pkg;

    localparam int NUM_PAGES_DEF = 256;

    localparam int CNT_W    = 9;   // page_count, register and pages_changed width
    localparam int IDX_W    = 8;   // page_index and base_page width
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_USED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_PAGES   = 2'd2;

    typedef enum logic [1:0] {
        PG_FREE  = 2'd0,
        PG_USED  = 2'd1,
        PG_FIXED = 2'd2
    } cpa_page_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_NOSPACE  = 3'd1,
        STAT_NOTREADY = 3'd2,
        STAT_FIXED    = 3'd3,
        STAT_BADINDEX = 3'd4
    } cpa_status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_INIT,
        FSM_ASCAN,
        FSM_AMARK,
        FSM_FLOOK,
        FSM_FCHECK,
        FSM_FSWEEP,
        FSM_DONE
    } cpa_fsm_t;

endpackage

FILE: hw/rtl/contiguous_page_allocator.sv
// Items that need the map are worked on with sweeps of the page map memory, one page per
// cycle on its single read port (an alloc scans, then marks its run); one item at a time.
// Results wait in an output register, so the next word can be taken meanwhile.
// rst_n (async, low) clears control, sets registers to 256/1/1 and marks the map unready;
// the map memory is not cleared, it is only read after an init has rewritten it.
`include "contiguous_page_allocator_assert.svh"

module contiguous_page_allocator
    import cpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,    // [8:0] page_count, [16:9] page_index
    input  logic [KIND_W-1:0]    s_tuser,    // [1:0] kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,    // [2:0] status, [10:3] base_page, [19:11] pages_changed
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW = (PW + 1 > 11) ? PW + 1 : 11;

    // map memories
    cpa_page_t        state_mem [NUM_PAGES];
    logic [CNT_W-1:0] len_mem   [NUM_PAGES];

    logic [PW-1:0]    rd_addr;
    cpa_page_t        rd_state_reg;
    logic [CNT_W-1:0] rd_len_reg;
    logic             st_we;
    logic [PW-1:0]    st_waddr;
    cpa_page_t        st_wdata;
    logic             ln_we;
    logic [PW-1:0]    ln_waddr;
    logic [CNT_W-1:0] ln_wdata;

    // control and payload registers
    cpa_fsm_t         fsm_reg, fsm_next;
    logic             map_ready_reg, map_ready_next;
    logic [CNT_W-1:0] total_pages_reg, boot_used_reg, map_pages_reg;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    issue_reg, issue_next;
    logic [CW-1:0]    end_reg, end_next;
    logic             pv_reg, pv_next;
    logic [PW-1:0]    paddr_reg, paddr_next;
    logic [CNT_W-1:0] run_len_reg, run_len_next;
    logic [PW-1:0]    run_start_reg, run_start_next;
    logic [PW-1:0]    mark_addr_reg, mark_addr_next;
    logic [CNT_W-1:0] mark_left_reg, mark_left_next;
    logic [CW-1:0]    changed_reg, changed_next;
    cpa_status_t      res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_base_reg, res_base_next;
    logic [CNT_W-1:0] res_changed_reg, res_changed_next;
    logic             out_valid_reg, out_valid_next;
    cpa_status_t      out_status_reg, out_status_next;
    logic [IDX_W-1:0] out_base_reg, out_base_next;
    logic [CNT_W-1:0] out_changed_reg, out_changed_next;

    // shared combinational terms
    logic [CNT_W-1:0]  in_count;
    logic [IDX_W-1:0]  in_idx;
    logic              accept;
    logic [CW-1:0]     t_pages;
    logic [CW-1:0]     fixed_end;
    logic              quick;
    cpa_status_t       quick_status;
    logic              issuing;
    logic              sweep_done;
    logic [CNT_W-1:0]  run_len_inc;
    logic [PW-1:0]     scan_base;
    logic              found;
    logic              is_fixed;
    logic              out_load;
    logic              mark_last;
    logic [CW-1:0]     page_ext;
    cpa_page_t         init_new;
    cpa_page_t         init_old;
    logic [CNT_W-1:0]  free_len;
    logic [CW-1:0]     free_end;

    assign in_count = s_tdata[CNT_W-1:0];
    assign in_idx   = s_tdata[CNT_W+IDX_W-1:CNT_W];
    assign s_tready = (fsm_reg == FSM_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign t_pages   = (CW'(total_pages_reg) < CW'(NUM_PAGES)) ? CW'(total_pages_reg)
                                                               : CW'(NUM_PAGES);
    assign fixed_end = CW'(boot_used_reg) + CW'(map_pages_reg);

    // answers that need no map access
    always_comb
    begin
        quick        = 1'b0;
        quick_status = STAT_OK;
        case (s_tuser)
            KIND_INIT:
            begin
                quick = 1'b0;
            end
            KIND_ALLOC:
            begin
                if (!map_ready_reg)
                begin
                    quick        = 1'b1;
                    quick_status = STAT_NOTREADY;
                end
                else if (in_count == '0 || CW'(in_count) > t_pages)
                begin
                    quick        = 1'b1;
                    quick_status = STAT_NOSPACE;
                end
            end
            KIND_FREE:
            begin
                if (!map_ready_reg)
                begin
                    quick        = 1'b1;
                    quick_status = STAT_NOTREADY;
                end
                else if (CW'(in_idx) >= t_pages)
                begin
                    quick        = 1'b1;
                    quick_status = STAT_BADINDEX;
                end
            end
            default:
            begin
                quick        = 1'b1;
                quick_status = STAT_BADINDEX;
            end
        endcase
    end

    assign issuing    = (fsm_reg == FSM_INIT || fsm_reg == FSM_ASCAN || fsm_reg == FSM_FSWEEP)
                        && (issue_reg < end_reg);
    assign sweep_done = (issue_reg >= end_reg) && !pv_reg;
    assign run_len_inc = run_len_reg + 1'b1;
    assign scan_base   = (run_len_reg == '0) ? paddr_reg : run_start_reg;
    assign found       = (fsm_reg == FSM_ASCAN) && pv_reg && (rd_state_reg == PG_FREE)
                         && (run_len_inc == count_reg);
    assign is_fixed    = (rd_state_reg == PG_FIXED);
    assign out_load    = (fsm_reg == FSM_DONE) && (!out_valid_reg || m_tready);
    assign mark_last   = (mark_left_reg == CNT_W'(1));

    assign rd_addr = (fsm_reg == FSM_FLOOK) ? idx_reg[PW-1:0]
                   : (issuing ? issue_reg[PW-1:0] : '0);

    // init layout of one page
    always_comb
    begin
        page_ext = CW'(paddr_reg);
        init_new = PG_FREE;
        if (page_ext < t_pages)
        begin
            if (page_ext == '0 || page_ext < CW'(boot_used_reg))
                init_new = PG_USED;
            else if (page_ext < fixed_end)
                init_new = PG_FIXED;
        end
        init_old = map_ready_reg ? rd_state_reg : PG_FREE;
    end

    // span of a free item
    always_comb
    begin
        free_len = (rd_len_reg == '0) ? CNT_W'(1) : rd_len_reg;
        free_end = idx_reg + CW'(free_len);
        if (free_end > t_pages)
            free_end = t_pages;
    end

    // next state
    always_comb
    begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    if (quick)
                        fsm_next = FSM_DONE;
                    else if (s_tuser == KIND_INIT)
                        fsm_next = FSM_INIT;
                    else if (s_tuser == KIND_ALLOC)
                        fsm_next = FSM_ASCAN;
                    else
                        fsm_next = FSM_FLOOK;
                end
            end
            FSM_INIT:
            begin
                if (sweep_done)
                    fsm_next = FSM_DONE;
            end
            FSM_ASCAN:
            begin
                if (found)
                    fsm_next = FSM_AMARK;
                else if (sweep_done)
                    fsm_next = FSM_DONE;
            end
            FSM_AMARK:
            begin
                if (mark_last)
                    fsm_next = FSM_DONE;
            end
            FSM_FLOOK:
            begin
                fsm_next = FSM_FCHECK;
            end
            FSM_FCHECK:
            begin
                fsm_next = is_fixed ? FSM_DONE : FSM_FSWEEP;
            end
            FSM_FSWEEP:
            begin
                if (sweep_done)
                    fsm_next = FSM_DONE;
            end
            FSM_DONE:
            begin
                if (out_load)
                    fsm_next = FSM_IDLE;
            end
            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        map_ready_next   = map_ready_reg;
        kind_next        = kind_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        issue_next       = issuing ? issue_reg + 1'b1 : issue_reg;
        end_next         = end_reg;
        pv_next          = issuing;
        paddr_next       = issue_reg[PW-1:0];
        run_len_next     = run_len_reg;
        run_start_next   = run_start_reg;
        mark_addr_next   = mark_addr_reg;
        mark_left_next   = mark_left_reg;
        changed_next     = changed_reg;
        res_status_next  = res_status_reg;
        res_base_next    = res_base_reg;
        res_changed_next = res_changed_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_base_next    = out_base_reg;
        out_changed_next = out_changed_reg;
        st_we    = 1'b0;
        st_waddr = paddr_reg;
        st_wdata = PG_FREE;
        ln_we    = 1'b0;
        ln_waddr = paddr_reg;
        ln_wdata = '0;

        case (fsm_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    kind_next        = s_tuser;
                    count_next       = in_count;
                    idx_next         = CW'(in_idx);
                    issue_next       = '0;
                    end_next         = (s_tuser == KIND_INIT) ? CW'(NUM_PAGES) : t_pages;
                    run_len_next     = '0;
                    changed_next     = '0;
                    res_status_next  = quick ? quick_status : STAT_OK;
                    res_base_next    = '0;
                    res_changed_next = '0;
                end
            end
            FSM_INIT:
            begin
                if (pv_reg)
                begin
                    st_we    = 1'b1;
                    st_wdata = init_new;
                    ln_we    = 1'b1;
                    if (init_old != init_new)
                        changed_next = changed_reg + 1'b1;
                end
                if (sweep_done)
                begin
                    map_ready_next   = 1'b1;
                    res_changed_next = changed_reg[CNT_W-1:0];
                end
            end
            FSM_ASCAN:
            begin
                if (pv_reg)
                begin
                    if (rd_state_reg == PG_FREE)
                    begin
                        run_len_next   = run_len_inc;
                        run_start_next = scan_base;
                    end
                    else
                    begin
                        run_len_next = '0;
                    end
                end
                if (found)
                begin
                    // length lives at the run's first page
                    ln_we            = 1'b1;
                    ln_waddr         = scan_base;
                    ln_wdata         = count_reg;
                    mark_addr_next   = scan_base;
                    mark_left_next   = count_reg;
                    res_base_next    = IDX_W'(CW'(scan_base));
                    res_changed_next = count_reg;
                end
                else if (sweep_done)
                begin
                    res_status_next = STAT_NOSPACE;
                end
            end
            FSM_AMARK:
            begin
                st_we          = 1'b1;
                st_waddr       = mark_addr_reg;
                st_wdata       = PG_USED;
                mark_addr_next = mark_addr_reg + 1'b1;
                mark_left_next = mark_left_reg - 1'b1;
            end
            FSM_FLOOK:
            begin
                issue_next = issue_reg;
            end
            FSM_FCHECK:
            begin
                if (is_fixed)
                begin
                    res_status_next = STAT_FIXED;
                end
                else
                begin
                    ln_we      = 1'b1;
                    ln_waddr   = idx_reg[PW-1:0];
                    issue_next = idx_reg;
                    end_next   = free_end;
                end
            end
            FSM_FSWEEP:
            begin
                if (pv_reg && rd_state_reg == PG_USED)
                begin
                    st_we        = 1'b1;
                    changed_next = changed_reg + 1'b1;
                end
                if (sweep_done)
                    res_changed_next = changed_reg[CNT_W-1:0];
            end
            FSM_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_base_next    = res_base_reg;
                    out_changed_next = res_changed_reg;
                end
            end
            default:
            begin
                pv_next = 1'b0;
            end
        endcase
    end

    // map memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (st_we)
            state_mem[st_waddr] <= st_wdata;
        if (ln_we)
            len_mem[ln_waddr] <= ln_wdata;
        rd_state_reg <= state_mem[rd_addr];
        rd_len_reg   <= len_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= FSM_IDLE;
            map_ready_reg   <= 1'b0;
            pv_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            total_pages_reg <= 9'd256;
            boot_used_reg   <= 9'd1;
            map_pages_reg   <= 9'd1;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            map_ready_reg <= map_ready_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TOTAL_PAGES: total_pages_reg <= cfg_data;
                    REG_BOOT_USED:   boot_used_reg   <= cfg_data;
                    REG_MAP_PAGES:   map_pages_reg   <= cfg_data;
                    default:         map_pages_reg   <= map_pages_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        count_reg       <= count_next;
        idx_reg         <= idx_next;
        issue_reg       <= issue_next;
        end_reg         <= end_next;
        paddr_reg       <= paddr_next;
        run_len_reg     <= run_len_next;
        run_start_reg   <= run_start_next;
        mark_addr_reg   <= mark_addr_next;
        mark_left_reg   <= mark_left_next;
        changed_reg     <= changed_next;
        res_status_reg  <= res_status_next;
        res_base_reg    <= res_base_next;
        res_changed_reg <= res_changed_next;
        out_status_reg  <= out_status_next;
        out_base_reg    <= out_base_next;
        out_changed_reg <= out_changed_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_changed_reg, out_base_reg, out_status_reg};

    `CPA_ASSERT_NEXT(a_accept_leaves_idle, accept, fsm_reg != FSM_IDLE)
    `CPA_ASSERT_NEXT(a_done_loads_output, out_load, m_tvalid)
    `CPA_ASSERT_IMPL(a_ready_sticks, 1'b1, !$fell(map_ready_reg))
    `CPA_ASSERT_IMPL(a_mark_in_map, fsm_reg == FSM_AMARK,
                     CW'(mark_addr_reg) < t_pages && kind_reg == KIND_ALLOC)

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for contiguous_page_allocator with a built-in page map predictor.
module tb
    import cpa_pkg::*;
();

    localparam int PAGES = NUM_PAGES_DEF;
    localparam logic [KIND_W-1:0] KIND_BOGUS = 2'd3;
    localparam int HOLD_CYCLES = 2500;
    localparam int HOLD_SPACING = 700;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 600;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  index;
    } page_req_t;

    typedef struct packed {
        cpa_status_t       status;
        logic [IDX_W-1:0]  base;
        logic [CNT_W-1:0]  changed;
    } page_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data = '0;

    // Predicted page map and register copies
    cpa_page_t        pg_state [PAGES];
    logic [CNT_W-1:0] run_len [PAGES];
    logic             map_live;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] boot_reg;
    logic [CNT_W-1:0] mapsz_reg;

    page_req_t   request_q [$];
    page_reply_t replies_due [$];
    page_req_t   feed_word;
    page_req_t   seen_req;
    page_reply_t seen_reply;
    page_reply_t want_reply;

    int  cycle = 0;
    int  words_in = 0;
    int  hold_left = 0;
    int  next_hold = 150;
    int  err_count = 0;
    int  n_settings = 0;
    int  n_alloc_ok = 0;
    int  n_free_ok = 0;
    int  n_refused = 0;
    logic calm;

    assign calm = (cycle >= 30000) && (cycle < 80000);

    contiguous_page_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int managed_pages();
        return (total_reg < PAGES) ? int'(total_reg) : PAGES;
    endfunction

    // Advance the predicted map by one request and return the reply it earns.
    function automatic page_reply_t apply_request(page_req_t r);
        page_reply_t rep;
        cpa_page_t   ns;
        int          t, fixed_end, n, cnt, base, j, stop, i;
        rep.status = STAT_OK;
        rep.base = '0;
        rep.changed = '0;
        t = managed_pages();
        cnt = 0;
        case (r.kind)
            KIND_INIT:
            begin
                fixed_end = int'(boot_reg) + int'(mapsz_reg);
                for (i = 0; i < PAGES; i++)
                begin
                    ns = PG_FREE;
                    if (i < t)
                    begin
                        if (i == 0 || i < int'(boot_reg))
                            ns = PG_USED;
                        else if (i < fixed_end)
                            ns = PG_FIXED;
                    end
                    if (pg_state[i] != ns)
                        cnt++;
                    pg_state[i] = ns;
                    run_len[i] = '0;
                end
                map_live = 1'b1;
                rep.changed = cnt[CNT_W-1:0];
            end
            KIND_ALLOC:
            begin
                n = int'(r.count);
                if (!map_live)
                    rep.status = STAT_NOTREADY;
                else if (n == 0 || n > t)
                    rep.status = STAT_NOSPACE;
                else
                begin
                    rep.status = STAT_NOSPACE;
                    base = 0;
                    while (base + n <= t && rep.status != STAT_OK)
                    begin
                        j = 0;
                        while (j < n && pg_state[base + j] == PG_FREE)
                            j++;
                        if (j == n)
                        begin
                            for (i = base; i < base + n; i++)
                                pg_state[i] = PG_USED;
                            run_len[base] = r.count;
                            rep.status = STAT_OK;
                            rep.base = base[IDX_W-1:0];
                            rep.changed = r.count;
                        end
                        else
                            base = base + j + 1;   // skip past the blocking page
                    end
                end
            end
            KIND_FREE:
            begin
                if (!map_live)
                    rep.status = STAT_NOTREADY;
                else if (int'(r.index) >= t)
                    rep.status = STAT_BADINDEX;
                else if (pg_state[r.index] == PG_FIXED)
                    rep.status = STAT_FIXED;
                else
                begin
                    n = (run_len[r.index] == 0) ? 1 : int'(run_len[r.index]);
                    stop = int'(r.index) + n;
                    if (stop > t)
                        stop = t;
                    for (i = int'(r.index); i < stop; i++)
                    begin
                        if (pg_state[i] == PG_USED)
                        begin
                            pg_state[i] = PG_FREE;
                            cnt++;
                        end
                    end
                    run_len[r.index] = '0;
                    rep.changed = cnt[CNT_W-1:0];
                end
            end
            default:
                rep.status = STAT_BADINDEX;
        endcase
        return rep;
    endfunction

    // Sender: hold a word until taken, idle at random otherwise
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (request_q.size() > 0 && (calm || $urandom_range(99) >= 14))
            begin
                feed_word = request_q.pop_front();
                s_tuser <= feed_word.kind;
                s_tdata <= {7'b0, feed_word.index, feed_word.count};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls plus long hold-offs that back up the block
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (words_in >= next_hold)
            begin
                hold_left <= HOLD_CYCLES;
                next_hold <= next_hold + HOLD_SPACING;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 14);
        end
    end

    // Monitor: track register writes, predict on accepted requests, check replies
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TOTAL_PAGES: total_reg = cfg_data;
                    REG_BOOT_USED:   boot_reg = cfg_data;
                    REG_MAP_PAGES:   mapsz_reg = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                seen_reply.status = cpa_status_t'(m_tdata[2:0]);
                seen_reply.base = m_tdata[10:3];
                seen_reply.changed = m_tdata[19:11];
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected reply, expected none,", $time);
                    $display("    got status %0d base %0d changed %0d",
                             seen_reply.status, seen_reply.base, seen_reply.changed);
                    err_count++;
                end
                else
                begin
                    want_reply = replies_due.pop_front();
                    if (seen_reply !== want_reply)
                    begin
                        $display("%0t: reply mismatch, expected status %0d base %0d changed %0d,",
                                 $time, want_reply.status, want_reply.base, want_reply.changed);
                        $display("    got status %0d base %0d changed %0d",
                                 seen_reply.status, seen_reply.base, seen_reply.changed);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                seen_req.kind = s_tuser;
                seen_req.count = s_tdata[8:0];
                seen_req.index = s_tdata[16:9];
                want_reply = apply_request(seen_req);
                if (want_reply.status == STAT_OK && seen_req.kind == KIND_ALLOC)
                    n_alloc_ok++;
                else if (want_reply.status == STAT_OK && seen_req.kind == KIND_FREE)
                    n_free_ok++;
                else if (want_reply.status != STAT_OK)
                    n_refused++;
                replies_due.push_back(want_reply);
                words_in <= words_in + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d replies outstanding",
                     cycle, replies_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_req(input logic [KIND_W-1:0] kind, input int count, input int index);
        page_req_t r;
        r.kind = kind;
        r.count = count[CNT_W-1:0];
        r.index = index[IDX_W-1:0];
        request_q.push_back(r);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || s_tvalid || replies_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Refill the request queue in batches; frees mostly target runs that are live right now.
    task automatic queue_random(input int n_items);
        page_req_t r;
        int        live [$];
        int        t, made, pick, sz, i;
        made = 0;
        while (made < n_items)
        begin
            @(negedge clk);
            if (request_q.size() < 4)
            begin
                t = managed_pages();
                if (t == 0)
                    t = 1;
                live.delete();
                for (i = 0; i < PAGES; i++)
                    if (run_len[i] != 0)
                        live.push_back(i);
                repeat (16)
                begin
                    if (made < n_items)
                    begin
                        pick = $urandom_range(99);
                        r.count = CNT_W'($urandom);
                        r.index = IDX_W'($urandom);
                        if (pick < 3)
                            r.kind = KIND_INIT;
                        else if (pick < 6)
                            r.kind = KIND_BOGUS;
                        else if (pick < 53)
                        begin
                            r.kind = KIND_ALLOC;
                            sz = $urandom_range(9);
                            if (sz < 6)
                                r.count = CNT_W'($urandom_range(8, 1));
                            else if (sz < 8)
                                r.count = CNT_W'($urandom_range(32, 1));
                            else if (sz < 9)
                                r.count = CNT_W'($urandom_range(t, 1));
                            else
                                r.count = CNT_W'($urandom_range(511));
                        end
                        else
                        begin
                            r.kind = KIND_FREE;
                            if (live.size() > 0 && $urandom_range(3) != 0)
                                r.index = IDX_W'(live[$urandom_range(live.size() - 1)]);
                            else if ($urandom_range(1) == 0)
                                r.index = IDX_W'($urandom_range(t - 1));
                        end
                        request_q.push_back(r);
                        made++;
                    end
                end
            end
        end
    endtask

    task automatic run_phase(input int total, input int boot, input int mapsz,
                             input int n_items, input bit with_init);
        write_reg(REG_TOTAL_PAGES, total);
        write_reg(REG_BOOT_USED, boot);
        write_reg(REG_MAP_PAGES, mapsz);
        n_settings++;
        if (with_init)
            push_req(KIND_INIT, 0, 0);
        queue_random(n_items);
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < PAGES; i++)
        begin
            pg_state[i] = PG_FREE;
            run_len[i] = '0;
        end
        map_live = 1'b0;
        total_reg = 9'd256;
        boot_reg = 9'd1;
        mapsz_reg = 9'd1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass under the reset register values
        n_settings = 1;
        push_req(KIND_ALLOC, 5, 0);       // map not laid out yet
        push_req(KIND_FREE, 0, 0);
        push_req(KIND_BOGUS, 0, 0);
        push_req(KIND_INIT, 0, 0);
        push_req(KIND_ALLOC, 0, 0);       // zero-length request
        push_req(KIND_ALLOC, 257, 0);     // longer than the map
        push_req(KIND_ALLOC, 511, 255);
        push_req(KIND_ALLOC, 256, 0);
        push_req(KIND_ALLOC, 255, 0);
        push_req(KIND_ALLOC, 254, 0);     // every free page at once
        push_req(KIND_ALLOC, 1, 0);
        push_req(KIND_FREE, 0, 1);        // map page is fixed
        push_req(KIND_FREE, 0, 2);
        push_req(KIND_ALLOC, 3, 0);
        push_req(KIND_ALLOC, 250, 0);
        push_req(KIND_FREE, 0, 255);      // top page, not a run start
        push_req(KIND_FREE, 0, 4);        // middle of a run
        push_req(KIND_FREE, 0, 0);        // boot page
        push_req(KIND_ALLOC, 1, 0);
        push_req(KIND_FREE, 511, 5);
        push_req(KIND_BOGUS, 511, 255);
        push_req(KIND_INIT, 511, 255);
        wait_drained();

        run_phase(256, 1, 1, 380, 1'b1);
        run_phase(64, 4, 3, 120, 1'b1);
        run_phase(256, 0, 0, 150, 1'b1);
        run_phase(1, 0, 0, 40, 1'b1);
        run_phase(511, 511, 256, 30, 1'b1);
        run_phase(200, 100, 50, 120, 1'b0);   // shrink the map without relaying it
        run_phase(17, 2, 30, 80, 1'b1);
        run_phase(0, 0, 511, 25, 1'b1);
        run_phase($urandom_range(256, 1), $urandom_range(20), $urandom_range(20), 200, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            $display("%0t: %0d replies never arrived", $time, replies_due.size());
            err_count++;
        end

        $display("Sent %0d requests across %0d register settings, with back-pressure stalls",
                 words_in, n_settings);
        $display("Replies: %0d runs allocated, %0d frees, %0d refusals",
                 n_alloc_ok, n_free_ok, n_refused);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
